@@ design/lpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int IDX_W      = 40;
    localparam int PS_W       = 17;
    localparam int OFF_W      = 16;
    localparam int CNT_W      = 48;
    localparam int SLOT_OUT_W = 6;
    localparam int HALF_W     = 20;
    localparam int PROD_W     = IDX_W + PS_W;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ELEMENTS = 1'b1;

    localparam logic [PS_W-1:0]  PS_RESET    = 17'd256;
    localparam logic [PS_W-1:0]  PS_MAX      = 17'd65536;
    localparam logic [IDX_W-1:0] TOTAL_RESET = 40'd1048576;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic scan;
        logic decide;
        logic addr_victim;
        logic xf_lo;
        logic xf_hi;
        logic xf_cmp;
        logic xf_src_mem;
        logic xf_dst_ld;
        logic emit_acc;
        logic emit_fl;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic wb;
        logic fdirty;
    } t_sts;

endpackage

@@ design/lpc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: divide, slot scan, transfer length steps, result strobes.
// ----------------------------------------------------------------------------
module lpc_ctrl #(
    parameter int SLOTS = 8,
    parameter int PTR_W = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_action,
    input  lpc_pkg::t_sts       i_sts,
    output lpc_pkg::t_cmd       o_cmd,
    output logic [PTR_W-1:0]    o_ptr,
    output logic                o_busy
);
    import lpc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIV   = 5'd1;
    localparam logic [4:0] S_SCAN  = 5'd2;
    localparam logic [4:0] S_DRAIN = 5'd3;
    localparam logic [4:0] S_DEC   = 5'd4;
    localparam logic [4:0] S_VRD   = 5'd5;
    localparam logic [4:0] S_WB1   = 5'd6;
    localparam logic [4:0] S_WB2   = 5'd7;
    localparam logic [4:0] S_WBC   = 5'd8;
    localparam logic [4:0] S_LD1   = 5'd9;
    localparam logic [4:0] S_LD2   = 5'd10;
    localparam logic [4:0] S_LDC   = 5'd11;
    localparam logic [4:0] S_EMIT  = 5'd12;
    localparam logic [4:0] S_FRD   = 5'd13;
    localparam logic [4:0] S_F1    = 5'd14;
    localparam logic [4:0] S_F2    = 5'd15;
    localparam logic [4:0] S_FC    = 5'd16;
    localparam logic [4:0] S_FEMIT = 5'd17;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(SLOTS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(IDX_W - 1);

    logic [4:0]        r_state, n_state;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    n_ptr         = '0;
                    n_step        = '0;
                    n_state       = i_action ? S_FRD : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_ptr == PTR_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DRAIN: n_state = S_DEC;
            S_DEC: begin
                o_cmd.decide = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_EMIT;
                end else if (i_sts.wb) begin
                    n_state = S_VRD;
                end else begin
                    n_state = S_LD1;
                end
            end
            S_VRD: begin
                o_cmd.addr_victim = 1'b1;
                n_state           = S_WB1;
            end
            S_WB1: begin
                o_cmd.addr_victim = 1'b1;
                o_cmd.xf_src_mem  = 1'b1;
                o_cmd.xf_lo       = 1'b1;
                n_state           = S_WB2;
            end
            S_WB2: begin
                o_cmd.addr_victim = 1'b1;
                o_cmd.xf_src_mem  = 1'b1;
                o_cmd.xf_hi       = 1'b1;
                n_state           = S_WBC;
            end
            S_WBC: begin
                o_cmd.addr_victim = 1'b1;
                o_cmd.xf_src_mem  = 1'b1;
                o_cmd.xf_cmp      = 1'b1;
                n_state           = S_LD1;
            end
            S_LD1: begin
                o_cmd.xf_lo = 1'b1;
                n_state     = S_LD2;
            end
            S_LD2: begin
                o_cmd.xf_hi = 1'b1;
                n_state     = S_LDC;
            end
            S_LDC: begin
                o_cmd.xf_cmp    = 1'b1;
                o_cmd.xf_dst_ld = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_acc = 1'b1;
                n_state        = S_IDLE;
            end
            S_FRD: begin
                if (i_sts.fdirty) begin
                    n_state = S_F1;
                end else if (r_ptr == PTR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_F1: begin
                o_cmd.xf_src_mem = 1'b1;
                o_cmd.xf_lo      = 1'b1;
                n_state          = S_F2;
            end
            S_F2: begin
                o_cmd.xf_src_mem = 1'b1;
                o_cmd.xf_hi      = 1'b1;
                n_state          = S_FC;
            end
            S_FC: begin
                o_cmd.xf_src_mem = 1'b1;
                o_cmd.xf_cmp     = 1'b1;
                n_state          = S_FEMIT;
            end
            S_FEMIT: begin
                o_cmd.emit_fl = 1'b1;
                if (r_ptr == PTR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_FRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ptr  = r_ptr;
    assign o_busy = (r_state != S_IDLE);

endmodule

@@ design/lpc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_dp
// Datapath: config registers, index divider, slot tables, LRU scan,
// transfer length unit, counters and result registers.
// ----------------------------------------------------------------------------
module lpc_dp #(
    parameter int SLOTS = 8,
    parameter int PTR_W = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lpc_pkg::t_cmd                  i_cmd,
    input  logic [PTR_W-1:0]               i_ptr,
    output lpc_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpc_pkg::IDX_W-1:0]      i_cfg_data,
    input  logic [lpc_pkg::IDX_W-1:0]      i_element_index,
    output logic                           o_valid,
    output logic [lpc_pkg::SLOT_OUT_W-1:0] o_slot_used,
    output logic [lpc_pkg::OFF_W-1:0]      o_word_offset,
    output logic                           o_was_hit,
    output logic                           o_write_back,
    output logic [lpc_pkg::IDX_W-1:0]      o_write_back_page,
    output logic [lpc_pkg::PS_W-1:0]       o_write_back_length,
    output logic                           o_load_needed,
    output logic [lpc_pkg::IDX_W-1:0]      o_load_page,
    output logic [lpc_pkg::PS_W-1:0]       o_load_length,
    output logic [lpc_pkg::CNT_W-1:0]      o_hit_count,
    output logic [lpc_pkg::CNT_W-1:0]      o_fault_count,
    output logic                           o_last
);
    import lpc_pkg::*;

    logic [PS_W-1:0]  r_page_size;
    logic [IDX_W-1:0] r_total;

    logic [IDX_W-1:0] r_page_mem [SLOTS];
    logic [CNT_W-1:0] r_use_mem  [SLOTS];
    logic [IDX_W-1:0] r_pg_q;
    logic [CNT_W-1:0] r_use_q;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_dirty;
    logic [CNT_W-1:0] r_use_ctr;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_faults;

    logic [IDX_W-1:0] r_quo;
    logic [PS_W-1:0]  r_rem;

    logic             r_sen_d;
    logic [PTR_W-1:0] r_sptr_d;
    logic             r_hit_f, r_free_f;
    logic [PTR_W-1:0] r_hit_slot, r_free_slot, r_lru_slot, r_slot;
    logic [CNT_W-1:0] r_lru_use;
    logic             r_wbf;
    logic [IDX_W-1:0] r_wb_page;

    logic [PROD_W-1:0] r_acc;
    logic [PS_W-1:0]   r_wb_len, r_ld_len;

    logic [PS_W-1:0]          ps_eff;
    logic [PS_W:0]            rem_sh, rem_sub;
    logic                     rem_ge;
    logic [PTR_W-1:0]         rd_addr, victim;
    logic                     wb_need, flast;
    logic [IDX_W-1:0]         xf_op;
    logic [HALF_W-1:0]        mul_a;
    logic [HALF_W+PS_W-1:0]   mul_p;
    logic [IDX_W-1:0]         rest;
    logic [PS_W-1:0]          xf_len;
    logic [CNT_W-1:0]         n_use_ctr;
    logic [CNT_W-1:0]         n_hits, n_faults;

    always_comb begin
        if (r_page_size == '0) begin
            ps_eff = PS_W'(1);
        end else if (r_page_size > PS_MAX) begin
            ps_eff = PS_MAX;
        end else begin
            ps_eff = r_page_size;
        end
    end

    assign rem_sh  = {r_rem, r_quo[IDX_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, ps_eff});
    assign rem_sub = rem_sh - {1'b0, ps_eff};

    assign victim  = r_hit_f ? r_hit_slot : (r_free_f ? r_free_slot : r_lru_slot);
    assign wb_need = !r_hit_f && !r_free_f && r_dirty[r_lru_slot];
    assign rd_addr = i_cmd.addr_victim ? r_slot : i_ptr;

    assign o_sts.hit    = r_hit_f;
    assign o_sts.wb     = wb_need;
    assign o_sts.fdirty = r_valid[i_ptr] & r_dirty[i_ptr];

    always_comb begin
        flast = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if ((PTR_W'(i) > i_ptr) && r_valid[i] && r_dirty[i]) begin
                flast = 1'b0;
            end
        end
    end

    assign xf_op = i_cmd.xf_src_mem ? r_pg_q : r_quo;
    assign mul_a = i_cmd.xf_hi ? xf_op[IDX_W-1:HALF_W] : xf_op[HALF_W-1:0];
    assign mul_p = mul_a * ps_eff;
    assign rest  = r_total - r_acc[IDX_W-1:0];

    always_comb begin
        if (r_acc >= PROD_W'(r_total)) begin
            xf_len = '0;
        end else if (rest < IDX_W'(ps_eff)) begin
            xf_len = rest[PS_W-1:0];
        end else begin
            xf_len = ps_eff;
        end
    end

    assign n_use_ctr = r_use_ctr + 1'b1;
    assign n_hits    = r_hit_f ? r_hits + 1'b1 : r_hits;
    assign n_faults  = r_hit_f ? r_faults : r_faults + 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PS_RESET;
            r_total     <= TOTAL_RESET;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_use_ctr   <= '0;
            r_hits      <= '0;
            r_faults    <= '0;
            r_sen_d     <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PAGE_SIZE:      r_page_size <= i_cfg_data[PS_W-1:0];
                    REG_TOTAL_ELEMENTS: r_total     <= i_cfg_data;
                    default: ;
                endcase
            end
            r_sen_d <= i_cmd.scan;
            o_valid <= i_cmd.emit_acc | i_cmd.emit_fl;
            if (i_cmd.emit_acc) begin
                r_valid[r_slot] <= 1'b1;
                r_dirty[r_slot] <= 1'b1;
                r_use_ctr       <= n_use_ctr;
                r_hits          <= n_hits;
                r_faults        <= n_faults;
            end
            if (i_cmd.emit_fl) begin
                r_dirty[i_ptr] <= 1'b0;
            end
        end
    end

    // slot tables
    always_ff @(posedge i_clk) begin
        r_pg_q  <= r_page_mem[rd_addr];
        r_use_q <= r_use_mem[rd_addr];
        if (i_cmd.emit_acc) begin
            r_use_mem[r_slot] <= n_use_ctr;
            if (!r_hit_f) begin
                r_page_mem[r_slot] <= r_quo;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_sptr_d <= i_ptr;
        if (i_cmd.load_in) begin
            r_quo    <= i_element_index;
            r_rem    <= '0;
            r_hit_f  <= 1'b0;
            r_free_f <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[IDX_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[PS_W-1:0] : rem_sh[PS_W-1:0];
        end
        if (r_sen_d) begin
            if (!r_hit_f && r_valid[r_sptr_d] && (r_pg_q == r_quo)) begin
                r_hit_f    <= 1'b1;
                r_hit_slot <= r_sptr_d;
            end
            if (!r_free_f && !r_valid[r_sptr_d]) begin
                r_free_f    <= 1'b1;
                r_free_slot <= r_sptr_d;
            end
            if ((r_sptr_d == '0) || (r_use_q < r_lru_use)) begin
                r_lru_use  <= r_use_q;
                r_lru_slot <= r_sptr_d;
            end
        end
        if (i_cmd.decide) begin
            r_slot <= victim;
            r_wbf  <= wb_need;
        end
        if (i_cmd.xf_lo) begin
            r_acc <= PROD_W'(mul_p);
        end
        if (i_cmd.xf_hi) begin
            r_acc <= r_acc + PROD_W'({mul_p, HALF_W'(0)});
        end
        if (i_cmd.xf_cmp) begin
            if (i_cmd.xf_dst_ld) begin
                r_ld_len <= xf_len;
            end else begin
                r_wb_len  <= xf_len;
                r_wb_page <= r_pg_q;
            end
        end
        if (i_cmd.emit_acc) begin
            o_slot_used         <= SLOT_OUT_W'(r_slot);
            o_word_offset       <= r_rem[OFF_W-1:0];
            o_was_hit           <= r_hit_f;
            o_write_back        <= r_wbf;
            o_write_back_page   <= r_wbf ? r_wb_page : '0;
            o_write_back_length <= r_wbf ? r_wb_len : '0;
            o_load_needed       <= !r_hit_f;
            o_load_page         <= r_hit_f ? '0 : r_quo;
            o_load_length       <= r_hit_f ? '0 : r_ld_len;
            o_hit_count         <= n_hits;
            o_fault_count       <= n_faults;
            o_last              <= 1'b1;
        end
        if (i_cmd.emit_fl) begin
            o_slot_used         <= SLOT_OUT_W'(i_ptr);
            o_word_offset       <= '0;
            o_was_hit           <= 1'b0;
            o_write_back        <= 1'b1;
            o_write_back_page   <= r_wb_page;
            o_write_back_length <= r_wb_len;
            o_load_needed       <= 1'b0;
            o_load_page         <= '0;
            o_load_length       <= '0;
            o_hit_count         <= r_hits;
            o_fault_count       <= r_faults;
            o_last              <= flast;
        end
    end

endmodule

@@ design/lru_page_cache_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_controller
// Fully associative LRU page slot controller with flush support.
// ----------------------------------------------------------------------------
// An access keeps o_busy high through the 40-step bit-serial index divider,
// the slot scan through the single read port of the slot tables, the victim
// decision, an optional write-back length step and, on a fault, the load
// length step. A flush walks every slot and, for each dirty one, runs the
// length step and a result strobe. Each result is shown for one cycle on
// o_valid and cannot be held off; a new request is taken once o_busy drops.
module lru_page_cache_controller #(
    parameter int SLOTS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_action,
    input  logic [lpc_pkg::IDX_W-1:0]      i_element_index,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpc_pkg::IDX_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    output logic [lpc_pkg::SLOT_OUT_W-1:0] o_slot_used,
    output logic [lpc_pkg::OFF_W-1:0]      o_word_offset,
    output logic                           o_was_hit,
    output logic                           o_write_back,
    output logic [lpc_pkg::IDX_W-1:0]      o_write_back_page,
    output logic [lpc_pkg::PS_W-1:0]       o_write_back_length,
    output logic                           o_load_needed,
    output logic [lpc_pkg::IDX_W-1:0]      o_load_page,
    output logic [lpc_pkg::PS_W-1:0]       o_load_length,
    output logic [lpc_pkg::CNT_W-1:0]      o_hit_count,
    output logic [lpc_pkg::CNT_W-1:0]      o_fault_count,
    output logic                           o_last
);
    import lpc_pkg::*;

    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_cmd             cmd;
    t_sts             sts;
    logic [PTR_W-1:0] ptr;
    logic             busy;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = busy;

    lpc_ctrl #(.SLOTS(SLOTS), .PTR_W(PTR_W)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start & ~busy),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_ptr    (ptr),
        .o_busy   (busy)
    );

    lpc_dp #(.SLOTS(SLOTS), .PTR_W(PTR_W)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_ptr               (ptr),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_element_index     (i_element_index),
        .o_valid             (o_valid),
        .o_slot_used         (o_slot_used),
        .o_word_offset       (o_word_offset),
        .o_was_hit           (o_was_hit),
        .o_write_back        (o_write_back),
        .o_write_back_page   (o_write_back_page),
        .o_write_back_length (o_write_back_length),
        .o_load_needed       (o_load_needed),
        .o_load_page         (o_load_page),
        .o_load_length       (o_load_length),
        .o_hit_count         (o_hit_count),
        .o_fault_count       (o_fault_count),
        .o_last              (o_last)
    );

endmodule

@@ design/lpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks on request and result sequencing.
// ----------------------------------------------------------------------------
module lpc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic                           o_busy,
    input logic                           o_valid,
    input logic                           o_was_hit,
    input logic                           o_write_back,
    input logic [lpc_pkg::PS_W-1:0]       o_write_back_length,
    input logic                           o_load_needed,
    input logic [lpc_pkg::IDX_W-1:0]      o_load_page,
    input logic [lpc_pkg::PS_W-1:0]       o_load_length,
    input logic                           o_last
);

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request did not raise busy");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result strobe right after final result");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_hit) |-> (!o_load_needed && !o_write_back))
        else $error("hit with transfer");

    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_back) |-> (o_write_back_length == '0))
        else $error("write-back length without write-back");

    a_ld_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_load_needed) |-> (o_load_page == '0 && o_load_length == '0))
        else $error("load fields without load");

endmodule

bind lru_page_cache_controller lpc_checker u_lpc_checker (.*);

@@ dv/tb_lru_page_cache_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_cache_controller
// Self-checking testbench for the LRU page cache controller. A behavioral
// cache model predicts the results of every accepted access or flush request.
// A monitor compares each strobed result field by field with the oldest
// prediction. The run covers directed corner cases, then random traffic under
// several page size and array length settings and several sender idle rates.
// ----------------------------------------------------------------------------
module tb_lru_page_cache_controller;
    import lpc_pkg::*;

    localparam int   SLOTS     = 8;
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_used;
        logic [OFF_W-1:0]      word_offset;
        logic                  was_hit;
        logic                  write_back;
        logic [IDX_W-1:0]      write_back_page;
        logic [PS_W-1:0]       write_back_length;
        logic                  load_needed;
        logic [IDX_W-1:0]      load_page;
        logic [PS_W-1:0]       load_length;
        logic [CNT_W-1:0]      hit_count;
        logic [CNT_W-1:0]      fault_count;
        logic                  last;
    } t_page_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic                  i_action = 1'b0;
    logic [IDX_W-1:0]      i_element_index = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [IDX_W-1:0]      i_cfg_data = '0;
    logic                  o_valid;
    logic [SLOT_OUT_W-1:0] o_slot_used;
    logic [OFF_W-1:0]      o_word_offset;
    logic                  o_was_hit;
    logic                  o_write_back;
    logic [IDX_W-1:0]      o_write_back_page;
    logic [PS_W-1:0]       o_write_back_length;
    logic                  o_load_needed;
    logic [IDX_W-1:0]      o_load_page;
    logic [PS_W-1:0]       o_load_length;
    logic [CNT_W-1:0]      o_hit_count;
    logic [CNT_W-1:0]      o_fault_count;
    logic                  o_last;

    lru_page_cache_controller #(.SLOTS(SLOTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_action(i_action), .i_element_index(i_element_index),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_slot_used(o_slot_used),
        .o_word_offset(o_word_offset), .o_was_hit(o_was_hit),
        .o_write_back(o_write_back), .o_write_back_page(o_write_back_page),
        .o_write_back_length(o_write_back_length),
        .o_load_needed(o_load_needed), .o_load_page(o_load_page),
        .o_load_length(o_load_length), .o_hit_count(o_hit_count),
        .o_fault_count(o_fault_count), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cache model state
    logic [PS_W-1:0]  cur_page_size;
    logic [IDX_W-1:0] cur_total;
    logic [IDX_W-1:0] slot_page [SLOTS];
    logic             slot_valid [SLOTS];
    logic             slot_dirty [SLOTS];
    logic [CNT_W-1:0] slot_stamp [SLOTS];
    logic [CNT_W-1:0] use_stamp;
    logic [CNT_W-1:0] hits_seen;
    logic [CNT_W-1:0] faults_seen;

    t_page_result pending_results[$];
    int           err_count = 0;
    int           idle_pct = 0;

    function automatic logic [63:0] eff_page_size();
        logic [63:0] p;
        p = 64'(cur_page_size);
        if (p == 0) p = 1;
        if (p > 65536) p = 65536;
        return p;
    endfunction

    function automatic logic [PS_W-1:0] transfer_length(logic [IDX_W-1:0] page);
        logic [63:0] ps;
        logic [63:0] first;
        logic [63:0] rest;
        ps = eff_page_size();
        first = 64'(page) * ps;
        if (first >= 64'(cur_total)) return '0;
        rest = 64'(cur_total) - first;
        return (rest < ps) ? rest[PS_W-1:0] : ps[PS_W-1:0];
    endfunction

    task automatic model_reset();
        cur_page_size = PS_RESET;
        cur_total = TOTAL_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            slot_page[i] = '0;
            slot_valid[i] = 1'b0;
            slot_dirty[i] = 1'b0;
            slot_stamp[i] = '0;
        end
        use_stamp = '0;
        hits_seen = '0;
        faults_seen = '0;
    endtask

    task automatic predict_request(logic act, logic [IDX_W-1:0] idx);
        t_page_result r;
        logic [63:0] ps;
        logic [63:0] page;
        int slot;
        int n;
        if (act == OP_FLUSH) begin
            n = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && slot_dirty[i]) begin
                    r = '0;
                    r.slot_used = SLOT_OUT_W'(i);
                    r.write_back = 1'b1;
                    r.write_back_page = slot_page[i];
                    r.write_back_length = transfer_length(slot_page[i]);
                    r.hit_count = hits_seen;
                    r.fault_count = faults_seen;
                    slot_dirty[i] = 1'b0;
                    pending_results.push_back(r);
                    n++;
                end
            end
            if (n > 0) pending_results[$].last = 1'b1;
        end else begin
            ps = eff_page_size();
            page = 64'(idx) / ps;
            r = '0;
            r.word_offset = OFF_W'(64'(idx) % ps);
            slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot < 0 && slot_valid[i] && 64'(slot_page[i]) == page) slot = i;
            end
            if (slot >= 0) begin
                hits_seen++;
                r.was_hit = 1'b1;
            end else begin
                faults_seen++;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot < 0 && !slot_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 1; i < SLOTS; i++) begin
                        if (slot_stamp[i] < slot_stamp[slot]) slot = i;
                    end
                    if (slot_dirty[slot]) begin
                        r.write_back = 1'b1;
                        r.write_back_page = slot_page[slot];
                        r.write_back_length = transfer_length(slot_page[slot]);
                    end
                end
                r.load_needed = 1'b1;
                r.load_page = page[IDX_W-1:0];
                r.load_length = transfer_length(page[IDX_W-1:0]);
                slot_page[slot] = page[IDX_W-1:0];
                slot_valid[slot] = 1'b1;
            end
            use_stamp++;
            slot_stamp[slot] = use_stamp;
            slot_dirty[slot] = 1'b1;
            r.slot_used = SLOT_OUT_W'(slot);
            r.hit_count = hits_seen;
            r.fault_count = faults_seen;
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", field, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_page_result w;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_slot_used), 64'd0);
            end else begin
                w = pending_results.pop_front();
                if (o_slot_used !== w.slot_used)
                    report_mismatch("slot_used", 64'(o_slot_used), 64'(w.slot_used));
                if (o_word_offset !== w.word_offset)
                    report_mismatch("word_offset", 64'(o_word_offset), 64'(w.word_offset));
                if (o_was_hit !== w.was_hit)
                    report_mismatch("was_hit", 64'(o_was_hit), 64'(w.was_hit));
                if (o_write_back !== w.write_back)
                    report_mismatch("write_back", 64'(o_write_back), 64'(w.write_back));
                if (o_write_back_page !== w.write_back_page)
                    report_mismatch("write_back_page", 64'(o_write_back_page),
                                    64'(w.write_back_page));
                if (o_write_back_length !== w.write_back_length)
                    report_mismatch("write_back_length", 64'(o_write_back_length),
                                    64'(w.write_back_length));
                if (o_load_needed !== w.load_needed)
                    report_mismatch("load_needed", 64'(o_load_needed), 64'(w.load_needed));
                if (o_load_page !== w.load_page)
                    report_mismatch("load_page", 64'(o_load_page), 64'(w.load_page));
                if (o_load_length !== w.load_length)
                    report_mismatch("load_length", 64'(o_load_length), 64'(w.load_length));
                if (o_hit_count !== w.hit_count)
                    report_mismatch("hit_count", 64'(o_hit_count), 64'(w.hit_count));
                if (o_fault_count !== w.fault_count)
                    report_mismatch("fault_count", 64'(o_fault_count), 64'(w.fault_count));
                if (o_last !== w.last)
                    report_mismatch("last", 64'(o_last), 64'(w.last));
            end
        end
    end

    // start stays high across back-to-back requests; drop it only on a gap
    task automatic send_request(logic act, logic [IDX_W-1:0] idx);
        int gap;
        i_start <= 1'b1;
        i_action <= act;
        i_element_index <= idx;
        do @(posedge i_clk); while (o_busy);
        predict_request(act, idx);
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(6, 1);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || o_busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_PAGE_SIZE) cur_page_size = data[PS_W-1:0];
        else cur_total = data;
        @(posedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        logic [63:0] ps;
        logic [63:0] v;
        ps = eff_page_size();
        case ($urandom_range(9))
            0: v = {$urandom, $urandom};
            1: v = 64'(cur_total) + $urandom_range(3 * 65536);
            default: v = 64'($urandom_range(11)) * ps + ($urandom % ps);
        endcase
        return v[IDX_W-1:0];
    endfunction

    task automatic test_directed();
        idle_pct = 0;
        send_request(OP_ACCESS, '0);
        send_request(OP_ACCESS, '1);
        send_request(OP_FLUSH, '0);
        send_request(OP_FLUSH, '0);
        for (int i = 0; i < 9; i++) send_request(OP_ACCESS, 40'(i * 256 + 255));
        send_request(OP_ACCESS, 40'd300);
        send_request(OP_ACCESS, 40'd1048575);
        send_request(OP_FLUSH, '0);
        send_request(OP_ACCESS, 40'd5000);
        drain();
        write_register(REG_PAGE_SIZE, 40'd0);
        write_register(REG_TOTAL_ELEMENTS, 40'd1);
        send_request(OP_ACCESS, 40'd0);
        send_request(OP_ACCESS, 40'd1);
        send_request(OP_FLUSH, '0);
        drain();
        write_register(REG_PAGE_SIZE, 40'd131071);
        write_register(REG_TOTAL_ELEMENTS, 40'hFF_FFFF_FFFF);
        send_request(OP_ACCESS, 40'hFF_FFFF_FFFF);
        send_request(OP_ACCESS, 40'd65535);
        send_request(OP_FLUSH, '0);
        drain();
    endtask

    task automatic test_random_phase(logic [PS_W-1:0] ps, logic [IDX_W-1:0] total,
                                     int pct, int count);
        write_register(REG_PAGE_SIZE, 40'(ps));
        write_register(REG_TOTAL_ELEMENTS, total);
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) send_request(OP_FLUSH, {$urandom, $urandom});
            else send_request(OP_ACCESS, pick_index());
        end
        drain();
    endtask

    initial begin
        model_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(17'd1, 40'd7, 0, 27);
        test_random_phase(17'd100, 40'd1050 + $urandom_range(99), 58, 27);
        test_random_phase(17'd65536, 40'd300000, 19, 27);
        test_random_phase(17'd70000, 40'hFF_FFFF_FFFF, 58, 13);
        test_random_phase(17'd16, 40'd150, 0, 13);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
